// File: design/kvp_pkg.sv
// Package for the binary key/value request parser: codes, header layout, structs,
// and the opcode decode helpers. No dependencies.
package kvp_pkg;

    localparam int unsigned HDR_BYTES   = 24;
    localparam int unsigned HDR_IDX_W   = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HB_MAGIC    = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HB_OPCODE   = 5'd1;
    localparam logic [HDR_IDX_W-1:0] HB_KEY_HI   = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HB_KEY_LO   = 5'd3;
    localparam logic [HDR_IDX_W-1:0] HB_EXTRAS   = 5'd4;
    localparam logic [HDR_IDX_W-1:0] HB_DTYPE    = 5'd5;
    localparam logic [HDR_IDX_W-1:0] HB_RSV_HI   = 5'd6;
    localparam logic [HDR_IDX_W-1:0] HB_RSV_LO   = 5'd7;
    localparam logic [HDR_IDX_W-1:0] HB_BODY_0   = 5'd8;
    localparam logic [HDR_IDX_W-1:0] HB_BODY_1   = 5'd9;
    localparam logic [HDR_IDX_W-1:0] HB_BODY_2   = 5'd10;
    localparam logic [HDR_IDX_W-1:0] HB_BODY_3   = 5'd11;
    localparam logic [HDR_IDX_W-1:0] HB_OPQ_0    = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HB_OPQ_1    = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HB_OPQ_2    = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HB_OPQ_3    = 5'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY = 2'd1;

    localparam logic [7:0]  MAGIC_RESET   = 8'h80;
    localparam logic [15:0] MAX_KEY_RESET = 16'd250;

    // extras lengths per operation
    localparam logic [7:0] EXTRAS_GET   = 8'd4;
    localparam logic [7:0] EXTRAS_STORE = 8'd8;
    localparam logic [7:0] EXTRAS_ARITH = 8'd20;
    localparam logic [7:0] EXTRAS_NONE  = 8'd0;

    // wire opcodes with special decode
    localparam logic [7:0] OPC_LAST_PLAIN = 8'h08;
    localparam logic [7:0] OPC_GETQ       = 8'h09;
    localparam logic [7:0] OPC_NOOP       = 8'h0A;
    localparam logic [7:0] OPC_VERSION    = 8'h0B;
    localparam logic [7:0] OPC_GETK       = 8'h0C;
    localparam logic [7:0] OPC_GETKQ      = 8'h0D;
    localparam logic [7:0] OPC_APPEND     = 8'h0E;
    localparam logic [7:0] OPC_PREPEND    = 8'h0F;
    localparam logic [7:0] OPC_STAT       = 8'h10;
    localparam logic [7:0] OPC_SETQ       = 8'h11;
    localparam logic [7:0] OPC_ADDQ       = 8'h12;
    localparam logic [7:0] OPC_REPLACEQ   = 8'h13;
    localparam logic [7:0] OPC_DELETEQ    = 8'h14;
    localparam logic [7:0] OPC_INCRQ      = 8'h15;
    localparam logic [7:0] OPC_DECRQ      = 8'h16;
    localparam logic [7:0] OPC_QUITQ      = 8'h17;
    localparam logic [7:0] OPC_FLUSHQ     = 8'h18;
    localparam logic [7:0] OPC_APPENDQ    = 8'h19;
    localparam logic [7:0] OPC_PREPENDQ   = 8'h1A;

    typedef enum logic [3:0] {
        OP_GET     = 4'd0,
        OP_SET     = 4'd1,
        OP_ADD     = 4'd2,
        OP_REPLACE = 4'd3,
        OP_DELETE  = 4'd4,
        OP_INCR    = 4'd5,
        OP_DECR    = 4'd6,
        OP_QUIT    = 4'd7,
        OP_FLUSH   = 4'd8,
        OP_NOOP    = 4'd9,
        OP_VERSION = 4'd10,
        OP_APPEND  = 4'd11,
        OP_PREPEND = 4'd12,
        OP_STAT    = 4'd13
    } t_op;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_MAGIC     = 4'd1,
        ERR_OPCODE    = 4'd2,
        ERR_KEY_FORB  = 4'd3,
        ERR_KEY_LONG  = 4'd4,
        ERR_EXTRAS    = 4'd5,
        ERR_DATATYPE  = 4'd6,
        ERR_RESERVED  = 4'd7,
        ERR_BODY_SHORT = 4'd8,
        ERR_VALUE_FORB = 4'd9
    } t_err;

    typedef enum logic [2:0] {
        CLS_HEADER  = 3'd0,
        CLS_EXTRAS  = 3'd1,
        CLS_KEY     = 3'd2,
        CLS_VALUE   = 3'd3,
        CLS_DISCARD = 3'd4
    } t_class;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_ERROR  = 3'b100
    } t_phase;

    typedef struct packed {
        logic known;
        t_op  op;
        logic quiet;
        logic rkey;
    } t_decode;

    // captured header fields that feed the checks
    typedef struct packed {
        logic [7:0]  magic_seen;
        logic [7:0]  opcode;
        logic [15:0] key_len;
        logic [7:0]  extras_len;
        logic [7:0]  datatype;
        logic [15:0] reserved;
        logic [31:0] body_len;
    } t_hdr_regs;

    typedef struct packed {
        t_decode     dec;
        t_err        err;
        logic [31:0] value_len;
    } t_hdr_info;

    typedef struct packed {
        logic [7:0]  byte_out;
        t_class      byte_class;
        logic        header_done;
        t_err        error_code;
        t_op         operation;
        logic        quiet_flag;
        logic        return_key_flag;
        logic [31:0] value_length;
        logic [31:0] opaque_out;
        logic [63:0] cas_out;
        logic        request_last;
    } t_result;

    function automatic t_decode kvp_decode(input logic [7:0] code);
        t_decode d;
        d.known = 1'b1;
        d.op    = OP_GET;
        d.quiet = 1'b0;
        d.rkey  = 1'b0;
        if (code <= OPC_LAST_PLAIN) begin
            d.op = t_op'(code[3:0]);
        end else begin
            case (code)
                OPC_GETQ:     d.quiet = 1'b1;
                OPC_NOOP:     d.op = OP_NOOP;
                OPC_VERSION:  d.op = OP_VERSION;
                OPC_GETK:     d.rkey = 1'b1;
                OPC_GETKQ: begin
                    d.rkey  = 1'b1;
                    d.quiet = 1'b1;
                end
                OPC_APPEND:   d.op = OP_APPEND;
                OPC_PREPEND:  d.op = OP_PREPEND;
                OPC_STAT:     d.op = OP_STAT;
                OPC_SETQ, OPC_ADDQ, OPC_REPLACEQ, OPC_DELETEQ,
                OPC_INCRQ, OPC_DECRQ, OPC_QUITQ, OPC_FLUSHQ: begin
                    // quiet variants sit 0x10 above their plain opcode
                    d.op    = t_op'(code[3:0]);
                    d.quiet = 1'b1;
                end
                OPC_APPENDQ: begin
                    d.op    = OP_APPEND;
                    d.quiet = 1'b1;
                end
                OPC_PREPENDQ: begin
                    d.op    = OP_PREPEND;
                    d.quiet = 1'b1;
                end
                default:      d.known = 1'b0;
            endcase
        end
        return d;
    endfunction

    function automatic logic [7:0] kvp_req_extras(input t_op op);
        logic [7:0] n;
        unique case (op)
            OP_GET:                        n = EXTRAS_GET;
            OP_SET, OP_ADD, OP_REPLACE:    n = EXTRAS_STORE;
            OP_INCR, OP_DECR:              n = EXTRAS_ARITH;
            default:                       n = EXTRAS_NONE;
        endcase
        return n;
    endfunction

endpackage

// File: design/binary_kv_request_parser_unit.sv
// Top level of the byte-serial binary key/value request parser.
// Uses kvp_pkg, kvp_hdr_check and kvp_out_reg.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------------
//  in        i_in_valid / o_in_stall   i_stream_byte
//  out       o_out_valid / i_out_stall o_byte_out .. o_request_last (11 fields)
//  cfg       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request byte per cycle unless stalled; its result appears the next cycle.
// The header checks run on the 24th header byte from registers filled by earlier bytes.
// Synchronous active-low reset returns the parser to the start of a header.
// o_in_stall rises only while the result register is full and the output is stalled.
// After a header error every byte is discarded until reset.
module binary_kv_request_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_stream_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_byte_out,
    output logic [2:0]                      o_byte_class,
    output logic                            o_header_done,
    output logic [3:0]                      o_error_code,
    output logic [3:0]                      o_operation,
    output logic                            o_quiet_flag,
    output logic                            o_return_key_flag,
    output logic [31:0]                     o_value_length,
    output logic [31:0]                     o_opaque_out,
    output logic [63:0]                     o_cas_out,
    output logic                            o_request_last,
    input  logic                            i_cfg_we,
    input  logic [kvp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kvp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kvp_pkg::*;

    logic [7:0]           r_magic_cfg;
    logic [15:0]          r_max_key;
    t_phase               r_phase, n_phase;
    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [31:0]          r_body_idx, n_body_idx;
    t_hdr_regs            r_hdr, n_hdr;
    logic [31:0]          r_opaque, n_opaque;
    logic [63:0]          r_cas, n_cas;

    t_hdr_info info;
    t_result   res;
    t_result   out_res;
    logic      ready;
    logic      in_fire;
    logic      hdr_last;
    logic      body_last;
    logic [16:0] key_extras;
    logic [63:0] cas_now;

    assign o_in_stall = !ready;
    assign in_fire    = i_in_valid && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_cfg <= MAGIC_RESET;
            r_max_key   <= MAX_KEY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAGIC) begin
                r_magic_cfg <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_MAX_KEY) begin
                r_max_key <= i_cfg_data[15:0];
            end
        end
    end

    kvp_hdr_check u_check (
        .i_hdr         (r_hdr),
        .i_cfg_magic   (r_magic_cfg),
        .i_cfg_max_key (r_max_key),
        .o_info        (info)
    );

    assign key_extras = 17'(r_hdr.extras_len) + 17'(r_hdr.key_len);
    assign hdr_last   = (r_hdr_idx == HDR_LAST_IDX);
    assign body_last  = (r_body_idx == (r_hdr.body_len - 32'd1));
    assign cas_now    = {r_cas[55:0], i_stream_byte};

    // header byte capture
    always_comb begin
        n_hdr    = r_hdr;
        n_opaque = r_opaque;
        n_cas    = r_cas;
        unique case (r_hdr_idx)
            HB_MAGIC:   n_hdr.magic_seen = i_stream_byte;
            HB_OPCODE:  n_hdr.opcode = i_stream_byte;
            HB_KEY_HI:  n_hdr.key_len[15:8] = i_stream_byte;
            HB_KEY_LO:  n_hdr.key_len[7:0] = i_stream_byte;
            HB_EXTRAS:  n_hdr.extras_len = i_stream_byte;
            HB_DTYPE:   n_hdr.datatype = i_stream_byte;
            HB_RSV_HI:  n_hdr.reserved[15:8] = i_stream_byte;
            HB_RSV_LO:  n_hdr.reserved[7:0] = i_stream_byte;
            HB_BODY_0, HB_BODY_1, HB_BODY_2, HB_BODY_3:
                n_hdr.body_len = {r_hdr.body_len[23:0], i_stream_byte};
            // opaque is kept in wire order: first byte lands in bits 7:0
            HB_OPQ_0:   n_opaque[7:0]   = i_stream_byte;
            HB_OPQ_1:   n_opaque[15:8]  = i_stream_byte;
            HB_OPQ_2:   n_opaque[23:16] = i_stream_byte;
            HB_OPQ_3:   n_opaque[31:24] = i_stream_byte;
            default:    n_cas = cas_now;
        endcase
    end

    // result and phase control
    always_comb begin
        res          = '0;
        res.byte_out = i_stream_byte;
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_body_idx   = r_body_idx;
        unique case (r_phase)
            PH_HEADER: begin
                res.byte_class = CLS_HEADER;
                if (hdr_last) begin
                    res.header_done     = 1'b1;
                    res.error_code      = info.err;
                    res.operation       = info.dec.op;
                    res.quiet_flag      = info.dec.quiet;
                    res.return_key_flag = info.dec.rkey;
                    res.opaque_out      = r_opaque;
                    res.cas_out         = cas_now;
                    n_hdr_idx           = '0;
                    n_body_idx          = '0;
                    if (info.err != ERR_NONE) begin
                        n_phase = PH_ERROR;
                    end else begin
                        res.value_length = info.value_len;
                        if (r_hdr.body_len == '0) begin
                            res.request_last = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + 1'b1;
                end
            end
            PH_BODY: begin
                priority if (r_body_idx < 32'(r_hdr.extras_len)) res.byte_class = CLS_EXTRAS;
                else if (r_body_idx < 32'(key_extras))           res.byte_class = CLS_KEY;
                else                                             res.byte_class = CLS_VALUE;
                res.operation       = info.dec.op;
                res.quiet_flag      = info.dec.quiet;
                res.return_key_flag = info.dec.rkey;
                res.value_length    = info.value_len;
                res.opaque_out      = r_opaque;
                res.cas_out         = r_cas;
                if (body_last) begin
                    res.request_last = 1'b1;
                    n_phase          = PH_HEADER;
                    n_hdr_idx        = '0;
                    n_body_idx       = '0;
                end else begin
                    n_body_idx = r_body_idx + 32'd1;
                end
            end
            default: begin
                res.byte_class = CLS_DISCARD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= '0;
            r_body_idx <= '0;
            r_hdr      <= '0;
            r_opaque   <= '0;
            r_cas      <= '0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_body_idx <= n_body_idx;
            if (r_phase == PH_HEADER) begin
                r_hdr    <= n_hdr;
                r_opaque <= n_opaque;
                r_cas    <= n_cas;
            end
        end
    end

    kvp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire),
        .i_result    (res),
        .i_out_stall (i_out_stall),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_byte_out        = out_res.byte_out;
    assign o_byte_class      = out_res.byte_class;
    assign o_header_done     = out_res.header_done;
    assign o_error_code      = out_res.error_code;
    assign o_operation       = out_res.operation;
    assign o_quiet_flag      = out_res.quiet_flag;
    assign o_return_key_flag = out_res.return_key_flag;
    assign o_value_length    = out_res.value_length;
    assign o_opaque_out      = out_res.opaque_out;
    assign o_cas_out         = out_res.cas_out;
    assign o_request_last    = out_res.request_last;

endmodule

// File: design/kvp_hdr_check.sv
// Header decode and validation for the request parser.
// Combinational over the captured header fields; uses kvp_pkg.
module kvp_hdr_check (
    input  kvp_pkg::t_hdr_regs  i_hdr,
    input  logic [7:0]          i_cfg_magic,
    input  logic [15:0]         i_cfg_max_key,
    output kvp_pkg::t_hdr_info  o_info
);
    import kvp_pkg::*;

    t_decode     dec;
    logic        keyless;
    logic        takes_value;
    logic [16:0] key_extras;
    logic [31:0] need;
    t_err        err;

    assign dec = kvp_decode(i_hdr.opcode);

    always_comb begin
        keyless     = (dec.op == OP_QUIT) || (dec.op == OP_FLUSH) ||
                      (dec.op == OP_NOOP) || (dec.op == OP_VERSION);
        takes_value = (dec.op == OP_SET) || (dec.op == OP_ADD) ||
                      (dec.op == OP_REPLACE) || (dec.op == OP_APPEND) ||
                      (dec.op == OP_PREPEND);
        key_extras  = 17'(i_hdr.extras_len) + 17'(i_hdr.key_len);
        need        = 32'(key_extras);

        priority if (i_hdr.magic_seen != i_cfg_magic)            err = ERR_MAGIC;
        else if (!dec.known)                                     err = ERR_OPCODE;
        else if (keyless && (i_hdr.key_len != '0))               err = ERR_KEY_FORB;
        else if (!keyless && (i_hdr.key_len > i_cfg_max_key))    err = ERR_KEY_LONG;
        else if (i_hdr.extras_len != kvp_req_extras(dec.op))     err = ERR_EXTRAS;
        else if (i_hdr.datatype != '0)                           err = ERR_DATATYPE;
        else if (i_hdr.reserved != '0)                           err = ERR_RESERVED;
        else if (i_hdr.body_len < need)                          err = ERR_BODY_SHORT;
        else if (!takes_value && (i_hdr.body_len != need))       err = ERR_VALUE_FORB;
        else                                                     err = ERR_NONE;

        o_info.dec       = dec;
        o_info.err       = err;
        o_info.value_len = i_hdr.body_len - need;
    end

endmodule

// File: design/kvp_out_reg.sv
// Result register for the request parser: holds one per-byte parser result
// until the downstream side takes it. Uses kvp_pkg for the result struct.
module kvp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kvp_pkg::t_result  i_result,
    input  logic              i_out_stall,
    output logic              o_ready,
    output logic              o_out_valid,
    output kvp_pkg::t_result  o_result
);
    import kvp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // a new result may enter when the slot is empty or drains this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
